FILE: design/mmhq_pkg.sv
// ----------------------------------------------------------------------------
// mmhq_pkg
// Shared types, constants and helpers of the min-max heap queue.
// ----------------------------------------------------------------------------
package mmhq_pkg;

  localparam int CAPACITY = 1023;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  // candidate positions reach four times a position plus six
  localparam int IDX_W    = CNT_W + 2;
  localparam int NCAND    = 6;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REM_MIN = 3'd1,
    OP_REM_MAX = 3'd2,
    OP_REM_AT  = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RA_RD, S_RA_CAP, S_DN_CHK, S_DN_RD, S_DN_SEL,
    S_LAST_RD, S_LAST_CAP, S_UP_P, S_UP_PC, S_UP_G, S_UP_GC, S_UP_FIN,
    S_RF0, S_RF1, S_RF2, S_RF3, S_DONE
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] val;
  } cand_t;

  // true when the position lies on a min level (root level is min)
  function automatic logic on_min_level(input logic [CNT_W-1:0] i);
    logic [CNT_W:0] v;
    logic           odd;
    v   = {1'b0, i} + 1'b1;
    odd = 1'b0;
    for (int b = 0; b <= CNT_W; b++) begin
      if (v[b]) odd = b[0];
    end
    return !odd;
  endfunction

endpackage

FILE: design/mmhq_pick.sv
// ----------------------------------------------------------------------------
// mmhq_pick
// Select the best child or grandchild of a hole on its way down.
// ----------------------------------------------------------------------------
module mmhq_pick
  import mmhq_pkg::*;
(
  input  logic             minl,
  input  logic [CNT_W-1:0] n,
  input  logic [IDX_W-1:0] fc,
  input  logic [KEY_W-1:0] cval [NCAND],
  output logic [CNT_W-1:0] best_idx,
  output logic [KEY_W-1:0] best_val
);

  // first argument wins ties
  function automatic cand_t better(input logic m, input cand_t a, input cand_t b);
    if (m) return (a.val <= b.val) ? a : b;
    return (a.val >= b.val) ? a : b;
  endfunction

  logic [IDX_W-1:0] fg;
  logic [IDX_W-1:0] nx;
  cand_t c0, c1, g0, g1, g2, g3, best;

  always_comb begin
    fg = {fc[IDX_W-2:0], 1'b1};
    nx = {{(IDX_W-CNT_W){1'b0}}, n};
    c0 = '{idx: fc,        val: cval[0]};
    c1 = '{idx: fc + 1'b1, val: cval[1]};
    g0 = '{idx: fg,        val: cval[2]};
    g1 = '{idx: fg + 2'd1, val: cval[3]};
    g2 = '{idx: fg + 2'd2, val: cval[4]};
    g3 = '{idx: fg + 2'd3, val: cval[5]};
    if (fg + 2'd3 < nx)
      best = better(minl, better(minl, g3, g2), better(minl, g1, g0));
    else if (fg + 2'd2 < nx)
      best = better(minl, better(minl, g2, g1), g0);
    else if (fg + 2'd1 < nx)
      best = better(minl, c1, better(minl, g1, g0));
    else if (fg < nx)
      best = better(minl, better(minl, g0, c1), c0);
    else if (fc + 1'b1 < nx)
      best = better(minl, c1, c0);
    else
      best = c0;
    best_idx = best.idx[CNT_W-1:0];
    best_val = best.val;
  end

endmodule

FILE: design/min_max_heap_queue.sv
// ----------------------------------------------------------------------------
// min_max_heap_queue
// Double-ended priority queue held as a min-max heap in one on-chip memory.
// ----------------------------------------------------------------------------
// Insert: the new key sifts up from the end, checked against its parent once,
//   then climbs grandparent by grandparent. Read fetches one entry.
// Removal: each step down reads up to 6 candidates through the single read
//   port and moves the best into the hole; the last entry then fills the hole
//   and sifts up, and the root entries are refreshed (states S_RF0 to S_RF3).
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset (synchronous, rst_n low): count cleared, heap empty; the memory is not
//   cleared, entries at or above the count are never read for a result.
module min_max_heap_queue
  import mmhq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_opcode,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [CNT_W-1:0]  in_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [KEY_W-1:0]  out_data_key,
  output logic [KEY_W-1:0]  out_min_key,
  output logic [KEY_W-1:0]  out_max_key,
  output logic [CNT_W-1:0]  out_entry_count
);

  // heap memory: one write and one registered read a cycle
  logic [KEY_W-1:0]  mem [CAPACITY];
  logic [KEY_W-1:0]  mem_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [KEY_W-1:0]  mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  op_t               op_r, op_nxt;
  status_t           stat_r, stat_nxt;
  logic [KEY_W-1:0]  data_r, data_nxt;
  logic [KEY_W-1:0]  v_r, v_nxt;          // element being sifted up
  logic [CNT_W-1:0]  i_r, i_nxt;          // current hole / element position
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              dminl_r, dminl_nxt;  // order used on the way down
  logic [2:0]        k_r, k_nxt;          // candidate read counter
  logic              pend_r, pend_nxt;
  logic [2:0]        pk_r, pk_nxt;
  logic [KEY_W-1:0]  cv_r [NCAND];
  logic [KEY_W-1:0]  h0_r, h1_r, h2_r;    // cached root and its children
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        o_stat_r;
  logic [KEY_W-1:0]  o_data_r, o_min_r, o_max_r;
  logic [CNT_W-1:0]  o_cnt_r;

  // candidate positions below the hole
  logic [IDX_W-1:0]  fc, fg, cand;
  logic [IDX_W-1:0]  nx;
  logic [CNT_W-1:0]  best_idx;
  logic [KEY_W-1:0]  best_val;
  logic [CNT_W-1:0]  par, gpar;
  logic              upminl;
  logic [KEY_W-1:0]  maxv;

  always_comb begin
    fc = {1'b0, i_r, 1'b1};
    fg = {i_r, 2'b11};
    nx = {{(IDX_W-CNT_W){1'b0}}, cnt_r};
    case (k_r)
      3'd0:    cand = fc;
      3'd1:    cand = fc + 1'b1;
      3'd2:    cand = fg;
      3'd3:    cand = fg + 2'd1;
      3'd4:    cand = fg + 2'd2;
      default: cand = fg + 2'd3;
    endcase
    par    = (i_r - 1'b1) >> 1;
    gpar   = (i_r - 2'd3) >> 2;
    upminl = on_min_level(i_r);
    // largest key: root alone, else larger child with position one on a tie
    if (cnt_r <= 1)      maxv = h0_r;
    else if (cnt_r == 2) maxv = h1_r;
    else                 maxv = (h1_r >= h2_r) ? h1_r : h2_r;
  end

  mmhq_pick u_pick (
    .minl     (dminl_r),
    .n        (cnt_r),
    .fc       (fc),
    .cval     (cv_r),
    .best_idx (best_idx),
    .best_val (best_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    stat_r  <= stat_nxt;
    data_r  <= data_nxt;
    v_r     <= v_nxt;
    i_r     <= i_nxt;
    pos_r   <= pos_nxt;
    dminl_r <= dminl_nxt;
    k_r     <= k_nxt;
    pk_r    <= pk_nxt;
    if (pend_r) cv_r[pk_r] <= mem_q;
    case (state_r)
      S_RF1:   h0_r <= mem_q;
      S_RF2:   h1_r <= mem_q;
      S_RF3:   h2_r <= mem_q;
      default: ;
    endcase
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      o_stat_r <= stat_r;
      o_data_r <= data_r;
      o_cnt_r  <= cnt_r;
      o_min_r  <= (cnt_r != 0) ? h0_r : '0;
      o_max_r  <= (cnt_r != 0) ? maxv : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    stat_nxt      = stat_r;
    data_nxt      = data_r;
    v_nxt         = v_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    dminl_nxt     = dminl_r;
    k_nxt         = k_r;
    pk_nxt        = pk_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_wa        = i_r[ADDR_W-1:0];
    mem_wd        = v_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(in_opcode);
          pos_nxt  = in_position;
          stat_nxt = ST_OK;
          data_nxt = '0;
          state_nxt = S_DONE;
          case (op_t'(in_opcode))
            OP_INSERT: begin
              if (cnt_r >= CNT_W'(CAPACITY)) begin
                stat_nxt = ST_FULL;
              end else begin
                v_nxt     = in_key;
                i_nxt     = cnt_r;
                cnt_nxt   = cnt_r + 1'b1;
                state_nxt = S_UP_P;
              end
            end
            OP_REM_MIN, OP_REM_MAX: begin
              if (cnt_r == 0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                // take the root, or the larger child of the root for max
                if (op_t'(in_opcode) == OP_REM_MIN || cnt_r == 1) begin
                  i_nxt = '0; data_nxt = h0_r;
                end else if (cnt_r == 2 || h1_r >= h2_r) begin
                  i_nxt = CNT_W'(1); data_nxt = h1_r;
                end else begin
                  i_nxt = CNT_W'(2); data_nxt = h2_r;
                end
                dminl_nxt = (op_t'(in_opcode) == OP_REM_MIN || cnt_r == 1);
                state_nxt = S_DN_CHK;
              end
            end
            OP_REM_AT: begin
              if (cnt_r == 0)                stat_nxt = ST_EMPTY;
              else if (in_position >= cnt_r) stat_nxt = ST_BADPOS;
              else                           state_nxt = S_RA_RD;
            end
            OP_CLEAR: cnt_nxt = '0;
            OP_READ: begin
              if (in_position >= cnt_r) stat_nxt = ST_BADPOS;
              else                      state_nxt = S_RA_RD;
            end
            default: ;
          endcase
        end
      end
      S_RA_RD: begin
        mem_re    = 1'b1;
        mem_ra    = pos_r[ADDR_W-1:0];
        state_nxt = S_RA_CAP;
      end
      S_RA_CAP: begin
        data_nxt = mem_q;
        if (op_r == OP_READ) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = pos_r;
          dminl_nxt = on_min_level(pos_r);
          state_nxt = S_DN_CHK;
        end
      end
      // hole descent: stop once the hole has no child
      S_DN_CHK: begin
        k_nxt     = '0;
        state_nxt = (fc >= nx) ? S_LAST_RD : S_DN_RD;
      end
      S_DN_RD: begin
        if (k_r == 3'(NCAND)) begin
          state_nxt = S_DN_SEL;
        end else begin
          mem_re   = (cand < nx);
          mem_ra   = cand[ADDR_W-1:0];
          pend_nxt = (cand < nx);
          pk_nxt   = k_r;
          k_nxt    = k_r + 1'b1;
        end
      end
      S_DN_SEL: begin
        // pull the best candidate into the hole, move the hole down
        mem_we    = 1'b1;
        mem_wd    = best_val;
        i_nxt     = best_idx;
        state_nxt = S_DN_CHK;
      end
      S_LAST_RD: begin
        mem_re    = 1'b1;
        mem_ra    = ADDR_W'(cnt_r - 1'b1);
        state_nxt = S_LAST_CAP;
      end
      S_LAST_CAP: begin
        v_nxt     = mem_q;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = (i_r < cnt_r - 1'b1) ? S_UP_P : S_RF0;
      end
      // sift up: parent once, then grandparents
      S_UP_P: begin
        if (i_r == 0) begin
          state_nxt = S_UP_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = par[ADDR_W-1:0];
          state_nxt = S_UP_PC;
        end
      end
      S_UP_PC: begin
        if (upminl ? (v_r > mem_q) : (v_r < mem_q)) begin
          mem_we = 1'b1;
          mem_wd = mem_q;
          i_nxt  = par;
        end
        state_nxt = S_UP_G;
      end
      S_UP_G: begin
        if (i_r > 2) begin
          mem_re    = 1'b1;
          mem_ra    = gpar[ADDR_W-1:0];
          state_nxt = S_UP_GC;
        end else begin
          state_nxt = S_UP_FIN;
        end
      end
      S_UP_GC: begin
        if (upminl ? (v_r < mem_q) : (v_r > mem_q)) begin
          mem_we    = 1'b1;
          mem_wd    = mem_q;
          i_nxt     = gpar;
          state_nxt = S_UP_G;
        end else begin
          state_nxt = S_UP_FIN;
        end
      end
      S_UP_FIN: begin
        mem_we    = 1'b1;
        state_nxt = S_RF0;
      end
      // refresh cached root entries for min and max
      S_RF0: begin
        mem_re    = 1'b1;
        mem_ra    = '0;
        state_nxt = (cnt_r == 0) ? S_DONE : S_RF1;
      end
      S_RF1: begin
        mem_re    = 1'b1;
        mem_ra    = ADDR_W'(1);
        state_nxt = S_RF2;
      end
      S_RF2: begin
        mem_re    = 1'b1;
        mem_ra    = ADDR_W'(2);
        state_nxt = S_RF3;
      end
      S_RF3: state_nxt = S_DONE;
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_stat_r;
  assign out_data_key    = o_data_r;
  assign out_min_key     = o_min_r;
  assign out_max_key     = o_max_r;
  assign out_entry_count = o_cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY)) else $error("entry count above capacity");

  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wa < ADDR_W'(CAPACITY))) else $error("heap write out of range");

  a_rd_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (mem_ra < ADDR_W'(CAPACITY))) else $error("heap read out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result loaded over a pending one");

endmodule
